/* sv/mcbd_pkg.sv */
`timescale 1ns / 1ps

package mcbd_pkg;

    // Fixed field widths
    localparam int CFG_W   = 11;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int TEXEL_W = 32;
    localparam int RGB_W   = 24;
    localparam int CH_W    = 8;
    localparam int CSUM_W  = 9;
    localparam int SUM_W   = 3 * CSUM_W;
    localparam int LEVEL_W = 4;
    localparam int POS_W   = 9;

    // Defaults for the top-level parameters
    localparam int MAX_SIDE_DEF   = 1024;
    localparam int MAX_LEVELS_DEF = 10;

    localparam logic [CFG_W-1:0] SIDE_RESET   = CFG_W'(256);
    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    // Register map, one register per 32-bit word
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Texel traveling down the chain of levels
    typedef struct packed {
        logic             alive;
        logic [RGB_W-1:0] rgb;
    } t_item;

    // One finished result texel (level is implied by its slot)
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [RGB_W-1:0] rgb;
    } t_result;

    // Chain-wide control
    typedef struct packed {
        logic advance;
        logic restart;
    } t_chain_ctrl;

    // Per-channel sums of two RGB texels, 9 bits per channel
    function automatic logic [SUM_W-1:0] pair_sum(input logic [RGB_W-1:0] a,
                                                  input logic [RGB_W-1:0] b);
        logic [SUM_W-1:0] s;
        for (int c = 0; c < 3; c++) begin
            s[c*CSUM_W +: CSUM_W] = CSUM_W'(a[c*CH_W +: CH_W]) + CSUM_W'(b[c*CH_W +: CH_W]);
        end
        return s;
    endfunction

    // Rounded mean of two pair sums: (p + q + 2) / 4 per channel
    function automatic logic [RGB_W-1:0] box_average(input logic [SUM_W-1:0] p,
                                                     input logic [SUM_W-1:0] q);
        logic [RGB_W-1:0]  r;
        logic [CSUM_W:0]   t;
        for (int c = 0; c < 3; c++) begin
            t = (CSUM_W+1)'(p[c*CSUM_W +: CSUM_W]) + (CSUM_W+1)'(q[c*CSUM_W +: CSUM_W])
              + (CSUM_W+1)'(2);
            r[c*CH_W +: CH_W] = t[CSUM_W:2];
        end
        return r;
    endfunction

endpackage

/* sv/mcbd_cell.sv */
`timescale 1ns / 1ps

// One mip level: horizontal pairing, row buffer for even rows, 2x2 average.
// The result bundle of earlier levels passes through and this level adds its slot.
module mcbd_cell
    import mcbd_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int LEVEL      = 0,
    localparam int SW    = $clog2(MAX_SIDE + 1),
    localparam int NUM_W = $clog2(MAX_LEVELS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_chain_ctrl                 i_ctrl,
    input  logic [SW-1:0]               i_base_w,
    input  logic [SW-1:0]               i_base_h,
    input  t_item                       i_item,
    input  logic [NUM_W-1:0]            i_count,
    input  t_result [MAX_LEVELS-1:0]    i_res,
    output t_item                       o_item,
    output logic [NUM_W-1:0]            o_count,
    output t_result [MAX_LEVELS-1:0]    o_res
);

    localparam int CNT_W = $clog2(MAX_SIDE);
    localparam int DEPTH = ((MAX_SIDE >> (LEVEL + 1)) > 1) ? (MAX_SIDE >> (LEVEL + 1)) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [RGB_W-1:0] r_held;
    logic [SUM_W-1:0] r_row_sums [0:DEPTH-1];
    logic [SUM_W-1:0] r_rd, r_fwd_sum;
    logic             r_fwd;
    logic             r_alive;
    logic [RGB_W-1:0] r_rgb;
    logic [NUM_W-1:0] r_count;
    t_result [MAX_LEVELS-1:0] r_res, n_res;

    logic [SW-1:0]    w_shr, h_shr, pw, ph, col_ext, row_ext;
    logic             wide, tall, take, col_wrap, row_wrap;
    logic             col_drop, col_even, row_drop, row_even, emit;
    logic             held_wr, mem_wr;
    logic [CNT_W-1:0] x_pos, y_pos;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [SUM_W-1:0] hsum, vsum;
    logic [RGB_W-1:0] avg;

    // Sides of this level: base side halved LEVEL times, never below 1
    assign w_shr = i_base_w >> LEVEL;
    assign h_shr = i_base_h >> LEVEL;
    assign pw    = (w_shr == '0) ? SW'(1) : w_shr;
    assign ph    = (h_shr == '0) ? SW'(1) : h_shr;
    assign wide  = (pw != SW'(1));
    assign tall  = (ph != SW'(1));
    assign take  = i_item.alive && (wide || tall);

    // Position counters
    assign col_ext  = SW'(r_col);
    assign row_ext  = SW'(r_row);
    assign col_wrap = (col_ext + SW'(1)) >= pw;
    assign row_wrap = (row_ext + SW'(1)) >= ph;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_ctrl.restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_ctrl.advance && take) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Horizontal pairing; an odd last column is dropped
    assign col_drop = wide && (col_ext >= (pw & ~SW'(1)));
    assign col_even = wide && !r_col[0];
    assign hsum     = wide ? pair_sum(r_held, i_item.rgb) : pair_sum(i_item.rgb, i_item.rgb);
    assign x_pos    = r_col >> 1;
    assign held_wr  = i_ctrl.advance && take && !col_drop && col_even;

    // Vertical pairing through the row buffer; an odd last row is dropped
    assign row_drop = tall && (row_ext >= (ph & ~SW'(1)));
    assign row_even = tall && !r_row[0];
    assign y_pos    = r_row >> 1;
    assign wr_addr  = AW'(x_pos);
    assign rd_addr  = AW'(n_col >> 1);
    assign mem_wr   = i_ctrl.advance && take && !col_drop && !col_even && tall
                   && !row_drop && row_even;
    assign vsum     = !tall ? hsum : (r_fwd ? r_fwd_sum : r_rd);

    assign emit = take && !col_drop && !col_even && !row_drop && !row_even;
    assign avg  = box_average(hsum, vsum);

    always_ff @(posedge i_clk) begin
        if (held_wr) begin
            r_held <= i_item.rgb;
        end
    end

    // Row buffer: registered read at the next item's column pair
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_row_sums[wr_addr] <= hsum;
        end
        r_rd      <= r_row_sums[rd_addr];
        r_fwd_sum <= hsum;
    end

    // Same-address write in the read cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= mem_wr && (wr_addr == rd_addr);
        end
    end

    // Result bundle with this level's slot filled in
    always_comb begin
        n_res = i_res;
        if (emit) begin
            n_res[LEVEL] = '{col: POS_W'(x_pos), row: POS_W'(y_pos), rgb: avg};
        end
    end

    // Stage register toward the next level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_count <= '0;
        end else if (i_ctrl.advance) begin
            r_alive <= emit;
            r_count <= emit ? NUM_W'(LEVEL + 1) : i_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_rgb <= avg;
            r_res <= n_res;
        end
    end

    assign o_item  = '{alive: r_alive, rgb: r_rgb};
    assign o_count = r_count;
    assign o_res   = r_res;

endmodule

/* sv/mcbd_serial.sv */
`timescale 1ns / 1ps

// Output stage: takes a bundle of results from the chain end and sends them
// one per transfer, lowest level first.
module mcbd_serial
    import mcbd_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int NUM_W = $clog2(MAX_LEVELS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [NUM_W-1:0]            i_count,
    input  t_result [MAX_LEVELS-1:0]    i_res,
    input  logic                        i_stall,
    output logic                        o_take,
    output logic                        o_valid,
    output logic [LEVEL_W-1:0]          o_level,
    output logic [POS_W-1:0]            o_col,
    output logic [POS_W-1:0]            o_row,
    output logic [TEXEL_W-1:0]          o_texel,
    output logic                        o_last
);

    logic [NUM_W-1:0]         r_left;
    logic [LEVEL_W-1:0]       r_lvl;
    t_result [MAX_LEVELS-1:0] r_slots;

    logic load_ok, load, shift;

    // Free for a new bundle when empty or sending its last result
    assign load_ok = (r_left == '0) || ((r_left == NUM_W'(1)) && !i_stall);
    assign load    = (i_count != '0) && load_ok;
    assign shift   = (r_left != '0) && !i_stall;
    assign o_take  = (i_count == '0) || load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_lvl  <= '0;
        end else if (load) begin
            r_left <= i_count;
            r_lvl  <= LEVEL_W'(1);
        end else if (shift) begin
            r_left <= r_left - 1'b1;
            r_lvl  <= r_lvl + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slots <= i_res;
        end else if (shift) begin
            for (int j = 0; j < MAX_LEVELS - 1; j++) begin
                r_slots[j] <= r_slots[j+1];
            end
        end
    end

    assign o_valid = (r_left != '0);
    assign o_last  = (r_left == NUM_W'(1));
    assign o_level = r_lvl;
    assign o_col   = r_slots[0].col;
    assign o_row   = r_slots[0].row;
    assign o_texel = {ALPHA_OPAQUE, r_slots[0].rgb};

endmodule

/* sv/mip_chain_box_downsampler.sv */
`timescale 1ns / 1ps

// Mip chain builder. Base ARGB texels enter in raster order, one transfer per
// cycle unless stalled, and every level of the chain comes out as 2x2
// box-filtered texels (alpha 0xFF) tagged with level, column and row; the
// results of one base texel leave in level order, the last one flagged. Each
// level is one cell of a MAX_LEVELS-long chain, so a texel's results pass the
// registers of all MAX_LEVELS cells before they are loaded into the output
// stage. A new texel is taken every cycle; the input stalls only while the
// output stage still holds results, so a base texel that completes k levels
// occupies the output for k transfers (plus any output stall), on average
// about one output transfer per three inputs. Each level keeps its own row
// buffer of even-row pair sums; it needs no clearing after reset. Any register
// write restarts the image. A register above MAX_SIDE acts as MAX_SIDE; a base
// side of 0 or 1 makes the block consume texels silently.
module mip_chain_box_downsampler
    import mcbd_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // Base texel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TEXEL_W-1:0]   i_texel_in,
    // Mip texel output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LEVEL_W-1:0]   o_mip_level,
    output logic [POS_W-1:0]     o_out_col,
    output logic [POS_W-1:0]     o_out_row,
    output logic [TEXEL_W-1:0]   o_texel_out,
    output logic                 o_last_of_run
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int NUM_W = $clog2(MAX_LEVELS + 1);

    logic [CFG_W-1:0] r_image_width, r_image_height;
    logic             cfg_wr, img_ok, take;
    t_reg_idx         reg_idx;
    logic [SW-1:0]    side_w, side_h;
    t_chain_ctrl      ctrl;

    t_item                    chain_item [0:MAX_LEVELS];
    logic [NUM_W-1:0]         chain_cnt  [0:MAX_LEVELS];
    t_result [MAX_LEVELS-1:0] chain_res  [0:MAX_LEVELS];

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SIDE_RESET;
            r_image_height <= SIDE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // Effective base sides
    assign side_w = (int'(r_image_width) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(r_image_width);
    assign side_h = (int'(r_image_height) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(r_image_height);
    assign img_ok = (side_w > SW'(1)) && (side_h > SW'(1));

    assign ctrl    = '{advance: take, restart: cfg_wr};
    assign o_stall = !take;

    // Chain head
    assign chain_item[0] = '{alive: i_valid && img_ok, rgb: i_texel_in[RGB_W-1:0]};
    assign chain_cnt[0]  = '0;
    assign chain_res[0]  = '0;

    for (genvar gl = 0; gl < MAX_LEVELS; gl++) begin : g_cell
        mcbd_cell #(
            .MAX_SIDE   (MAX_SIDE),
            .MAX_LEVELS (MAX_LEVELS),
            .LEVEL      (gl)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_base_w (side_w),
            .i_base_h (side_h),
            .i_item   (chain_item[gl]),
            .i_count  (chain_cnt[gl]),
            .i_res    (chain_res[gl]),
            .o_item   (chain_item[gl+1]),
            .o_count  (chain_cnt[gl+1]),
            .o_res    (chain_res[gl+1])
        );
    end

    // Output stage
    mcbd_serial #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (chain_cnt[MAX_LEVELS]),
        .i_res   (chain_res[MAX_LEVELS]),
        .i_stall (i_stall),
        .o_take  (take),
        .o_valid (o_valid),
        .o_level (o_mip_level),
        .o_col   (o_out_col),
        .o_row   (o_out_row),
        .o_texel (o_texel_out),
        .o_last  (o_last_of_run)
    );

    // A texel alive past the last cell has a result at every level
    a_full_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_item[MAX_LEVELS].alive |-> chain_cnt[MAX_LEVELS] == NUM_W'(MAX_LEVELS))
        else $error("alive texel at chain end without a full result bundle");

    // Within one run the level steps up by one per transfer
    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=>
            o_valid && (o_mip_level == $past(o_mip_level) + LEVEL_W'(1)))
        else $error("mip level did not advance within a run");

    // Nothing enters level one without an accepted base texel of a usable image
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !(i_valid && img_ok) |=> !chain_item[1].alive)
        else $error("level one result without an accepted texel");

    // Reported level stays within the chain
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mip_level != '0) && (int'(o_mip_level) <= MAX_LEVELS))
        else $error("mip level out of range");

endmodule

/* bench/mip_texel_checker.sv */
`timescale 1ns / 1ps

// Watches the register port and both texel channels, predicts the mip texels
// that every base texel transfer produces, and compares them in order.
module mip_texel_checker
    import mcbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 pready,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic [TEXEL_W-1:0]   i_texel_in,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [LEVEL_W-1:0]   o_mip_level,
    input  logic [POS_W-1:0]     o_out_col,
    input  logic [POS_W-1:0]     o_out_row,
    input  logic [TEXEL_W-1:0]   o_texel_out,
    input  logic                 o_last_of_run,
    output int                   mismatches,
    output int                   pending
);

    localparam int SIDE_CAP  = MAX_SIDE_DEF;
    localparam int LEVEL_CAP = MAX_LEVELS_DEF;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [TEXEL_W-1:0] texel;
        logic               last;
    } t_mip_texel;

    // Predicted geometry and chain state
    logic [CFG_W-1:0]  cfg_width;
    logic [CFG_W-1:0]  cfg_height;
    logic [SUM_W-1:0]  even_row_sums [SIDE_CAP];
    logic [RGB_W-1:0]  left_rgb      [LEVEL_CAP];
    int unsigned       col_pos       [LEVEL_CAP];
    int unsigned       row_pos       [LEVEL_CAP];

    t_mip_texel expected_texels[$];

    // 9-bit per-channel sums of two RGB texels
    function automatic logic [SUM_W-1:0] sum_pairs(input logic [RGB_W-1:0] a,
                                                   input logic [RGB_W-1:0] b);
        logic [SUM_W-1:0] s;
        for (int c = 0; c < 3; c++)
            s[c*CSUM_W +: CSUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
        return s;
    endfunction

    // (four-texel sum + 2) / 4 per channel
    function automatic logic [RGB_W-1:0] box_mean(input logic [SUM_W-1:0] p,
                                                  input logic [SUM_W-1:0] q);
        logic [RGB_W-1:0] m;
        logic [CSUM_W:0]  t;
        for (int c = 0; c < 3; c++) begin
            t = {1'b0, p[c*CSUM_W +: CSUM_W]} + {1'b0, q[c*CSUM_W +: CSUM_W]} + 10'd2;
            m[c*CH_W +: CH_W] = t[CSUM_W:2];
        end
        return m;
    endfunction

    task automatic clear_image();
        for (int lv = 0; lv < LEVEL_CAP; lv++) begin
            left_rgb[lv] = '0;
            col_pos[lv]  = 0;
            row_pos[lv]  = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mip mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want, input t_mip_texel at);
        if (got !== want)
            report_mismatch($sformatf("level %0d (%0d,%0d) %s: got %0h, want %0h",
                                      at.level, at.col, at.row, name, got, want));
    endtask

    // Walk one base texel down the chain of levels and queue what comes out
    task automatic build_mip_texels(input logic [TEXEL_W-1:0] texel);
        int unsigned      w, h, nw, nh, col, row, x, y, idx;
        int               made;
        logic [RGB_W-1:0] cur;
        logic [SUM_W-1:0] hsum, vsum;
        t_mip_texel       chain_out [LEVEL_CAP];
        w    = (cfg_width  > SIDE_CAP) ? SIDE_CAP : cfg_width;
        h    = (cfg_height > SIDE_CAP) ? SIDE_CAP : cfg_height;
        cur  = texel[RGB_W-1:0];
        made = 0;
        // degenerate base: consumed silently
        if (w <= 1 || h <= 1)
            return;
        for (int lv = 0; lv < LEVEL_CAP; lv++) begin
            if (w <= 1 && h <= 1)
                break;
            nw  = (w > 1) ? w / 2 : 1;
            nh  = (h > 1) ? h / 2 : 1;
            col = col_pos[lv];
            row = row_pos[lv];
            // position counters wrap at the level's edge
            if (col + 1 >= w) begin
                col_pos[lv] = 0;
                row_pos[lv] = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col_pos[lv] = col + 1;
            end
            // horizontal pairing; a lone odd last column is dropped
            if (w > 1) begin
                if (col >= 2 * nw)
                    break;
                if (col % 2 == 0) begin
                    left_rgb[lv] = cur;
                    break;
                end
                hsum = sum_pairs(left_rgb[lv], cur);
                x    = col / 2;
            end else begin
                hsum = sum_pairs(cur, cur);
                x    = 0;
            end
            // vertical pairing through the even-row buffer
            if (h > 1) begin
                if (row >= 2 * nh)
                    break;
                idx = SIDE_CAP - (SIDE_CAP >> lv) + x;
                if (idx >= SIDE_CAP)
                    break;
                if (row % 2 == 0) begin
                    even_row_sums[idx] = hsum;
                    break;
                end
                vsum = even_row_sums[idx];
                y    = row / 2;
            end else begin
                vsum = hsum;
                y    = 0;
            end
            cur = box_mean(hsum, vsum);
            chain_out[made].level = LEVEL_W'(lv + 1);
            chain_out[made].col   = POS_W'(x);
            chain_out[made].row   = POS_W'(y);
            chain_out[made].texel = {ALPHA_OPAQUE, cur};
            chain_out[made].last  = 1'b0;
            made++;
            w = nw;
            h = nh;
        end
        for (int i = 0; i < made; i++) begin
            if (i == made - 1)
                chain_out[i].last = 1'b1;
            expected_texels = {expected_texels, chain_out[i]};
        end
    endtask

    // Outputs are checked before the new input transfer is predicted
    always @(posedge i_clk) begin
        t_mip_texel got;
        t_mip_texel want;
        if (!i_rst_n) begin
            cfg_width  = SIDE_RESET;
            cfg_height = SIDE_RESET;
            clear_image();
            expected_texels.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got.level = o_mip_level;
                got.col   = o_out_col;
                got.row   = o_out_row;
                got.texel = o_texel_out;
                got.last  = o_last_of_run;
                if (expected_texels.size() == 0) begin
                    report_mismatch($sformatf("unexpected texel level %0d (%0d,%0d) %0h",
                                              got.level, got.col, got.row, got.texel));
                end else begin
                    want = expected_texels.pop_front();
                    compare_field("mip_level", 32'(got.level), 32'(want.level), want);
                    compare_field("out_col", 32'(got.col), 32'(want.col), want);
                    compare_field("out_row", 32'(got.row), 32'(want.row), want);
                    compare_field("texel_out", got.texel, want.texel, want);
                    compare_field("last_of_run", 32'(got.last), 32'(want.last), want);
                end
            end
            // any register write restarts the image
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1:2] == REG_IMAGE_WIDTH)
                    cfg_width = pwdata[CFG_W-1:0];
                else if (paddr[ADDR_W-1:2] == REG_IMAGE_HEIGHT)
                    cfg_height = pwdata[CFG_W-1:0];
                clear_image();
            end
            if (i_valid && !o_stall)
                build_mip_texels(i_texel_in);
        end
        pending <= expected_texels.size();
    end

endmodule

/* bench/tb_mip_chain_box_downsampler.sv */
`timescale 1ns / 1ps

module tb_mip_chain_box_downsampler;
    import mcbd_pkg::*;

    localparam int CYCLE_LIMIT   = 800_000;
    localparam int SETTLE_CYCLES = 3 * MAX_LEVELS_DEF;
    localparam int RANDOM_TEXELS = 80;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } t_flow_style;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [ADDR_W-1:0]    paddr      = '0;
    logic [DATA_W-1:0]    pwdata     = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [TEXEL_W-1:0]   i_texel_in = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic [LEVEL_W-1:0]   o_mip_level;
    logic [POS_W-1:0]     o_out_col;
    logic [POS_W-1:0]     o_out_row;
    logic [TEXEL_W-1:0]   o_texel_out;
    logic                 o_last_of_run;

    int mismatches;
    int pending;
    int cycles;
    int burst_left = 0;
    int cur_w      = 256;
    int cur_h      = 256;

    t_flow_style flow       = FLOW_FREE;
    int          flow_span  = 0;

    // 4x4 image: black/white extremes, alpha noise, rounding corners
    logic [TEXEL_W-1:0] corner_texels [16] = '{
        32'hFF000000, 32'h00000000, 32'hFFFFFFFF, 32'h00FFFFFF,
        32'h7F000000, 32'h80000000, 32'h7FFFFFFF, 32'h80FFFFFF,
        32'h00020202, 32'h00000000, 32'h00FF0001, 32'h0000FF01,
        32'h00000000, 32'h00000000, 32'h00808080, 32'h007F7F7F
    };

    mip_chain_box_downsampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_texel_in    (i_texel_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mip_level   (o_mip_level),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_texel_out   (o_texel_out),
        .o_last_of_run (o_last_of_run)
    );

    mip_texel_checker u_mip_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_texel_in    (i_texel_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mip_level   (o_mip_level),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_texel_out   (o_texel_out),
        .o_last_of_run (o_last_of_run),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** mip_chain_box_downsampler: FAILED **");
        $finish;
    end

    // Output back-pressure: a new random style after each span of random length
    always @(negedge i_clk) begin
        if (flow_span == 0) begin
            flow      = t_flow_style'($urandom_range(0, 3));
            flow_span = $urandom_range(20, 300);
        end
        flow_span--;
        case (flow)
            FLOW_FREE:  i_stall = 1'b0;
            FLOW_LIGHT: i_stall = ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: i_stall = ($urandom_range(0, 3) != 0);
            default:    i_stall = ((flow_span % 16) < 5);
        endcase
    end

    // Register write: setup then access; called at a falling edge
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        logic [DATA_W-1:0] noise;
        noise   = $urandom;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = {noise[DATA_W-1:CFG_W], v};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_image(input int w, input int h);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        cur_w = w;
        cur_h = h;
    endtask

    // One texel transfer; bursts of random length with random gaps between
    task automatic send_texel(input logic [TEXEL_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_valid    = 1'b1;
        i_texel_in = t;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_texel($urandom);
    endtask

    // Drain: no input, all predicted texels back, pipeline flushed
    task automatic wait_quiet();
        i_valid    = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int random_sent;
        int pick;
        int w;
        int h;
        int n;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry 256x256: part of the first row, nothing comes out yet
        send_random(16);
        wait_quiet();

        // Corner values on a 4x4 image
        set_image(4, 4);
        foreach (corner_texels[i])
            send_texel(corner_texels[i]);
        wait_quiet();

        // Degenerate bases: nothing comes out
        set_image(0, 5);
        send_random(6);
        wait_quiet();
        set_image(1, 8);
        send_random(6);
        wait_quiet();
        set_image(8, 1);
        send_random(6);
        wait_quiet();

        // Smallest image, three in a row to cover wrap
        set_image(2, 2);
        send_random(12);
        wait_quiet();

        // Odd sides drop their last row and column
        set_image(3, 3);
        send_random(18);
        wait_quiet();

        // Wide and tall strips run several levels with a side of 1
        set_image(16, 2);
        send_random(32);
        wait_quiet();
        set_image(2, 16);
        send_random(32);
        wait_quiet();

        // Oversized height acts as the maximum
        set_image(2, 2047);
        send_random(16);
        wait_quiet();

        // Random small images, some cut short by the next write
        random_sent = 0;
        while (random_sent < RANDOM_TEXELS) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                w = $urandom_range(0, 1);
                h = $urandom_range(0, 40);
                if ($urandom_range(0, 1) != 0)
                    set_image(h, w);
                else
                    set_image(w, h);
                send_random($urandom_range(1, 6));
            end else begin
                h = $urandom_range(2, 5);
                if (pick == 1 && cur_w >= 2 && cur_w <= 5) begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
                    cur_h = h;
                end else begin
                    set_image($urandom_range(2, 5), h);
                end
                n = cur_w * cur_h * $urandom_range(1, 2);
                if (pick == 2)
                    n += $urandom_range(1, cur_w * cur_h - 1);
                send_random(n);
                random_sent += n;
            end
            wait_quiet();
        end

        wait_quiet();
        if (mismatches == 0 && pending == 0) begin
            $display("** mip_chain_box_downsampler: PASSED **");
        end else begin
            $display("** mip_chain_box_downsampler: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
sv/mcbd_pkg.sv
sv/mcbd_cell.sv
sv/mcbd_serial.sv
sv/mip_chain_box_downsampler.sv
bench/mip_texel_checker.sv
bench/tb_mip_chain_box_downsampler.sv
